@@ src/urs_pkg.sv @@
// Shared types and constants for the ultrasonic range obstacle stop block.
// Used by the top level, the port-level checks, the range checker and the testbench.
package urs_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD      = 3'd0,
        CFG_ALARM_THRESHOLD = 3'd1,
        CFG_STOP_DISTANCE   = 3'd2,
        CFG_RISE_TIMEOUT    = 3'd3,
        CFG_HIGH_TIMEOUT    = 3'd4,
        CFG_DISTANCE_SCALE  = 3'd5
    } t_cfg_idx;

    // Register reset values.
    localparam logic [15:0] RST_PWM_PERIOD      = 16'd1700;
    localparam logic [11:0] RST_ALARM_THRESHOLD = 12'd2047;
    localparam logic [15:0] RST_STOP_DISTANCE   = 16'd10;
    localparam logic [19:0] RST_RISE_TIMEOUT    = 20'd300000;
    localparam logic [19:0] RST_HIGH_TIMEOUT    = 20'd300000;
    localparam logic [13:0] RST_DISTANCE_SCALE  = 14'd343;

    // Trigger pulse shape in ticks.
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;

    // Distance = product / 10000. Products at or above 65536 * 10000 saturate;
    // below that the product fits 30 bits and a 31-bit reciprocal with a
    // 44-bit shift gives the exact quotient.
    localparam int          DIST_PROD_W = 30;
    localparam logic [29:0] DIST_SAT    = 30'd655360000;
    localparam logic [30:0] DIST_RECIP  = 31'd1759218605;
    localparam int          DIST_SHIFT  = 44;

    typedef struct packed {
        logic        start_req;
        logic [11:0] adc_sample;
        logic        echo_level;
    } t_in_item;

    typedef struct packed {
        logic        trigger_level;
        logic        busy_res;
        logic        done_res;
        logic        timed_out;
        logic [15:0] distance_cm;
        logic [15:0] motor_duty;
        logic        motor_forward;
        logic        alarm_on;
    } t_out_item;

endpackage

@@ src/urs_duty_div.sv @@
// Duty mapping unit: duty = sample * period / (2^SAMPLE_BITS - 1).
// Three clocked steps after a load; depends on nothing but its ports.
module urs_duty_div #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [15:0]            i_period,
    output logic [15:0]            o_duty
);
    localparam int XW     = SAMPLE_BITS + 16;
    localparam int NTERMS = (XW + SAMPLE_BITS - 1) / SAMPLE_BITS;
    localparam int FULL   = (1 << SAMPLE_BITS) - 1;

    logic [XW-1:0] r_x;
    logic [XW-1:0] r_q;
    logic [XW-1:0] r_rem;
    logic [15:0]   r_duty;
    logic [XW-1:0] n_q;
    logic [XW-1:0] n_rem;
    logic [XW-1:0] n_qc;

    // Dividing by 2^n - 1 is the series x/2^n + x/2^2n + ...; the truncated
    // sum underestimates by a few units, which the remainder step repairs.
    always_comb begin
        n_q = '0;
        for (int k = 1; k <= NTERMS; k++) begin
            n_q = n_q + (r_x >> (k * SAMPLE_BITS));
        end
        n_rem = r_x - (n_q << SAMPLE_BITS) + n_q;
    end

    always_comb begin
        n_qc = r_q;
        for (int c = 1; c <= NTERMS + 1; c++) begin
            if (r_rem >= XW'(c * FULL)) begin
                n_qc = n_qc + XW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= XW'(i_sample) * XW'(i_period);
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_duty <= n_qc[15:0];
    end

    assign o_duty = r_duty;

endmodule

@@ src/ultrasonic_range_obstacle_stop.sv @@
// Ultrasonic echo-ranging controller with obstacle stop. Each request is one
// timing tick, and the block takes one request in every clock cycle unless
// back-pressure from the result side holds it; a result for a tick leaves
// through a four-stage result pipeline (state update, width times scale,
// reciprocal multiply, distance and motor decision). The duty mapping settles
// after a start, well before the earliest possible end of a measurement.
// Depends on urs_pkg and urs_duty_div.
module ultrasonic_range_obstacle_stop #(
    parameter int TICK_COUNT_BITS = 20,
    parameter int SAMPLE_BITS     = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  urs_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output urs_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [urs_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    localparam int TW = TICK_COUNT_BITS;
    localparam int LW = (TW > 20) ? TW : 20;
    localparam int AW = (SAMPLE_BITS > 12) ? SAMPLE_BITS : 12;
    localparam int PW = TW + 14;
    localparam int RW = urs_pkg::DIST_PROD_W + 31;
    localparam logic [LW-1:0] CMAX = LW'((64'd1 << TW) - 64'd1);

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_TRIG_LOW   = 5'b00010,
        PH_TRIG_HIGH  = 5'b00100,
        PH_WAIT_RISE  = 5'b01000,
        PH_COUNT_HIGH = 5'b10000
    } t_phase;

    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic tmo;
        logic alarm;
    } t_flags;

    // Configuration registers.
    logic [15:0] r_pwm_period;
    logic [11:0] r_alarm_thr;
    logic [15:0] r_stop_dist;
    logic [19:0] r_rise_to;
    logic [19:0] r_high_to;
    logic [13:0] r_dist_scale;

    // Measurement state.
    t_phase        r_phase, n_phase;
    logic [TW-1:0] r_phase_ticks, n_phase_ticks;
    logic [TW-1:0] r_pulse_ticks, n_pulse_ticks;
    logic          r_alarm, n_alarm;
    logic          r_tmo, n_tmo;
    logic          n_done;
    logic          n_start;

    logic [TW-1:0]          tick_inc;
    logic [LW-1:0]          rise_ext, high_ext;
    logic [TW-1:0]          rise_lim, high_lim;
    logic [SAMPLE_BITS-1:0] sample;
    logic [15:0]            pend_duty;

    // Result pipeline.
    logic          r_v1, r_v2, r_v3, r_v4;
    logic          rdy1, rdy2, rdy3, rdy4;
    logic          accept;
    t_flags        r_s1_flags, r_s2_flags, r_s3_flags, r_s4_flags;
    logic [TW-1:0] r_s1_width;
    logic [15:0]   r_s1_duty, r_s2_duty, r_s3_duty;
    logic [PW-1:0] r_s2_prod;
    logic          r_s3_sat;
    logic [RW-1:0] r_s3_rprod;

    logic [15:0] r_last_dist;
    logic [15:0] r_applied;
    logic        r_fwd;
    logic [15:0] s4_quot;
    logic [15:0] s4_dist;

    assign rdy4       = !r_v4 || i_out_ready;
    assign rdy3       = !r_v3 || rdy4;
    assign rdy2       = !r_v2 || rdy3;
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_ready = rdy1;
    assign accept     = i_in_valid && rdy1;

    // Timeout limits: zero acts like one, and the count width clamps them.
    always_comb begin
        rise_ext = LW'(r_rise_to);
        high_ext = LW'(r_high_to);
        if (r_rise_to == '0) begin
            rise_lim = TW'(1);
        end else if (rise_ext > CMAX) begin
            rise_lim = CMAX[TW-1:0];
        end else begin
            rise_lim = rise_ext[TW-1:0];
        end
        if (r_high_to == '0) begin
            high_lim = TW'(1);
        end else if (high_ext > CMAX) begin
            high_lim = CMAX[TW-1:0];
        end else begin
            high_lim = high_ext[TW-1:0];
        end
    end

    assign sample   = SAMPLE_BITS'(i_in_data.adc_sample);
    assign tick_inc = r_phase_ticks + TW'(1);

    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_pulse_ticks = r_pulse_ticks;
        n_alarm       = r_alarm;
        n_tmo         = r_tmo;
        n_done        = 1'b0;
        n_start       = 1'b0;
        unique case (r_phase)
            PH_TRIG_LOW: begin
                n_phase_ticks = tick_inc;
                if (tick_inc >= TW'(urs_pkg::TRIG_LOW_TICKS - 1)) begin
                    n_phase       = PH_TRIG_HIGH;
                    n_phase_ticks = '0;
                end
            end
            PH_TRIG_HIGH: begin
                n_phase_ticks = tick_inc;
                if (tick_inc >= TW'(urs_pkg::TRIG_HIGH_TICKS)) begin
                    n_phase       = PH_WAIT_RISE;
                    n_phase_ticks = '0;
                end
            end
            PH_WAIT_RISE: begin
                if (i_in_data.echo_level) begin
                    n_phase       = PH_COUNT_HIGH;
                    n_phase_ticks = '0;
                    n_pulse_ticks = TW'(1);
                end else begin
                    n_phase_ticks = tick_inc;
                    if (tick_inc >= rise_lim) begin
                        n_phase       = PH_IDLE;
                        n_phase_ticks = '0;
                        n_tmo         = 1'b1;
                        n_done        = 1'b1;
                    end
                end
            end
            PH_COUNT_HIGH: begin
                if (i_in_data.echo_level) begin
                    if (r_pulse_ticks >= high_lim) begin
                        n_phase       = PH_IDLE;
                        n_phase_ticks = '0;
                        n_tmo         = 1'b1;
                        n_done        = 1'b1;
                    end else begin
                        n_pulse_ticks = r_pulse_ticks + TW'(1);
                    end
                end else begin
                    n_phase       = PH_IDLE;
                    n_phase_ticks = '0;
                    n_tmo         = 1'b0;
                    n_done        = 1'b1;
                end
            end
            default: begin
                // Idle, and any code that should never occur.
                n_phase = PH_IDLE;
                if (i_in_data.start_req) begin
                    n_start       = 1'b1;
                    n_alarm       = AW'(sample) > AW'(r_alarm_thr);
                    n_phase       = PH_TRIG_LOW;
                    n_phase_ticks = '0;
                    n_pulse_ticks = '0;
                end
            end
        endcase
    end

    urs_duty_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_duty_div (
        .i_clk   (i_clk),
        .i_load  (accept && n_start),
        .i_sample(sample),
        .i_period(r_pwm_period),
        .o_duty  (pend_duty)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period  <= urs_pkg::RST_PWM_PERIOD;
            r_alarm_thr   <= urs_pkg::RST_ALARM_THRESHOLD;
            r_stop_dist   <= urs_pkg::RST_STOP_DISTANCE;
            r_rise_to     <= urs_pkg::RST_RISE_TIMEOUT;
            r_high_to     <= urs_pkg::RST_HIGH_TIMEOUT;
            r_dist_scale  <= urs_pkg::RST_DISTANCE_SCALE;
        end else if (i_cfg_we) begin
            unique case (urs_pkg::t_cfg_idx'(i_cfg_idx))
                urs_pkg::CFG_PWM_PERIOD:      r_pwm_period <= i_cfg_wdata[15:0];
                urs_pkg::CFG_ALARM_THRESHOLD: r_alarm_thr  <= i_cfg_wdata[11:0];
                urs_pkg::CFG_STOP_DISTANCE:   r_stop_dist  <= i_cfg_wdata[15:0];
                urs_pkg::CFG_RISE_TIMEOUT:    r_rise_to    <= i_cfg_wdata[19:0];
                urs_pkg::CFG_HIGH_TIMEOUT:    r_high_to    <= i_cfg_wdata[19:0];
                urs_pkg::CFG_DISTANCE_SCALE:  r_dist_scale <= i_cfg_wdata[13:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_ticks <= '0;
            r_pulse_ticks <= '0;
            r_alarm       <= 1'b0;
            r_tmo         <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_pulse_ticks <= n_pulse_ticks;
            r_alarm       <= n_alarm;
            r_tmo         <= n_tmo;
        end
    end

    // Pipeline occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // The duty is copied into the request when it is taken, so a later start
    // cannot disturb a result that is still waiting downstream.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flags <= '{trig:  (n_phase == PH_TRIG_HIGH),
                            busy:  (n_phase != PH_IDLE),
                            done:  n_done,
                            tmo:   n_tmo,
                            alarm: n_alarm};
            r_s1_width <= r_pulse_ticks;
            r_s1_duty  <= pend_duty;
        end
        if (rdy2 && r_v1) begin
            r_s2_flags <= r_s1_flags;
            r_s2_prod  <= PW'(r_s1_width) * PW'(r_dist_scale);
            r_s2_duty  <= r_s1_duty;
        end
        if (rdy3 && r_v2) begin
            r_s3_flags <= r_s2_flags;
            r_s3_sat   <= r_s2_prod >= PW'(urs_pkg::DIST_SAT);
            r_s3_rprod <= RW'(r_s2_prod[urs_pkg::DIST_PROD_W-1:0]) * RW'(urs_pkg::DIST_RECIP);
            r_s3_duty  <= r_s2_duty;
        end
        if (rdy4 && r_v3) begin
            r_s4_flags <= r_s3_flags;
        end
    end

    assign s4_quot = r_s3_rprod[urs_pkg::DIST_SHIFT +: 16];

    always_comb begin
        if (r_s3_flags.tmo) begin
            s4_dist = '0;
        end else if (r_s3_sat) begin
            s4_dist = 16'hFFFF;
        end else begin
            s4_dist = s4_quot;
        end
    end

    // Distance and motor state change only when a finishing request reaches
    // the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_dist <= '0;
            r_applied   <= '0;
            r_fwd       <= 1'b0;
        end else if (rdy4 && r_v3 && r_s3_flags.done) begin
            r_last_dist <= s4_dist;
            if (s4_dist > r_stop_dist) begin
                r_applied <= r_s3_duty;
                r_fwd     <= 1'b1;
            end else begin
                r_applied <= '0;
                r_fwd     <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = '{trigger_level: r_s4_flags.trig,
                           busy_res:      r_s4_flags.busy,
                           done_res:      r_s4_flags.done,
                           timed_out:     r_s4_flags.tmo,
                           distance_cm:   r_last_dist,
                           motor_duty:    r_applied,
                           motor_forward: r_fwd,
                           alarm_on:      r_s4_flags.alarm};

endmodule

@@ src/urs_checker.sv @@
// Port-level checks for the ultrasonic range obstacle stop block, and the
// bind that attaches them to the top level. Depends on urs_pkg.
module urs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input urs_pkg::t_out_item o_out_data
);

    // A result that is not taken stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A timed-out measurement reports zero distance and a stopped motor.
    a_tmo_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.done_res && o_out_data.timed_out |->
            o_out_data.distance_cm == 16'd0 && !o_out_data.motor_forward)
        else $error("timeout did not stop the motor");

    // A released motor never carries a duty.
    a_duty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.motor_forward |-> o_out_data.motor_duty == 16'd0)
        else $error("duty driven while motor released");

    // Trigger only during a cycle, and a finishing tick is no longer busy.
    a_phase_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.trigger_level || o_out_data.busy_res) &&
            !(o_out_data.done_res && o_out_data.busy_res))
        else $error("inconsistent trigger, busy and done");

endmodule

bind ultrasonic_range_obstacle_stop urs_checker u_urs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

@@ tb/urs_range_checker.sv @@
// Port checker for the ultrasonic range obstacle stop block: mirrors the ranging
// state machine per accepted tick request and compares every result it emits.
// Depends on urs_pkg for the item structs, register indexes and reset values.
module urs_range_checker
    import urs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef enum logic [2:0] {
        RANGE_IDLE,
        RANGE_TRIG_LOW,
        RANGE_TRIG_HIGH,
        RANGE_WAIT_ECHO,
        RANGE_COUNT_ECHO
    } t_range_phase;

    localparam logic [11:0] SAMPLE_FULL = '1;

    // Register copies.
    logic [15:0] pwm_period_q;
    logic [11:0] alarm_thr_q;
    logic [15:0] stop_dist_q;
    logic [19:0] rise_tmo_q;
    logic [19:0] high_tmo_q;
    logic [13:0] scale_q;

    // Ranging state.
    t_range_phase phase_q;
    logic [19:0]  phase_ticks_q;
    logic [19:0]  pulse_ticks_q;
    logic [15:0]  pending_duty_q;
    logic [15:0]  applied_duty_q;
    logic [15:0]  distance_q;
    logic         fwd_q;
    logic         alarm_q;
    logic         tmo_q;

    t_out_item due_results[$];
    int        fail_cnt    = 0;
    int        result_cnt  = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // A timeout register of zero behaves like one.
    function automatic logic [19:0] tick_limit(input logic [19:0] r);
        return (r == '0) ? 20'd1 : r;
    endfunction

    function automatic logic [15:0] width_to_cm(input logic [19:0] ticks);
        logic [47:0] cm;
        cm = ({28'd0, ticks} * {34'd0, scale_q}) / 48'd10000;
        return (cm > 48'd65535) ? 16'hFFFF : cm[15:0];
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        fail_cnt++;
        if (fail_cnt <= 100)
            $display("result %0d: %s is %0d, expected %0d", result_cnt, field, got_v, want_v);
    endtask

    task automatic close_measurement(input logic tmo, input logic [19:0] ticks);
        logic [15:0] cm;
        cm = tmo ? 16'd0 : width_to_cm(ticks);
        distance_q = cm;
        tmo_q      = tmo;
        if (cm > stop_dist_q) begin
            applied_duty_q = pending_duty_q;
            fwd_q          = 1'b1;
        end else begin
            applied_duty_q = '0;
            fwd_q          = 1'b0;
        end
        phase_q       = RANGE_IDLE;
        phase_ticks_q = '0;
    endtask

    task automatic step_ranging(input t_in_item req, output t_out_item res);
        logic        done;
        logic [27:0] duty;
        done = 1'b0;
        case (phase_q)
            RANGE_TRIG_LOW: begin
                phase_ticks_q = phase_ticks_q + 1'b1;
                if (phase_ticks_q >= TRIG_LOW_TICKS - 1) begin
                    phase_q       = RANGE_TRIG_HIGH;
                    phase_ticks_q = '0;
                end
            end
            RANGE_TRIG_HIGH: begin
                phase_ticks_q = phase_ticks_q + 1'b1;
                if (phase_ticks_q >= TRIG_HIGH_TICKS) begin
                    phase_q       = RANGE_WAIT_ECHO;
                    phase_ticks_q = '0;
                end
            end
            RANGE_WAIT_ECHO: begin
                if (req.echo_level) begin
                    phase_q       = RANGE_COUNT_ECHO;
                    phase_ticks_q = '0;
                    pulse_ticks_q = 20'd1;
                end else begin
                    phase_ticks_q = phase_ticks_q + 1'b1;
                    if (phase_ticks_q >= tick_limit(rise_tmo_q)) begin
                        close_measurement(1'b1, '0);
                        done = 1'b1;
                    end
                end
            end
            RANGE_COUNT_ECHO: begin
                if (req.echo_level) begin
                    if (pulse_ticks_q >= tick_limit(high_tmo_q)) begin
                        close_measurement(1'b1, '0);
                        done = 1'b1;
                    end else begin
                        pulse_ticks_q = pulse_ticks_q + 1'b1;
                    end
                end else begin
                    close_measurement(1'b0, pulse_ticks_q);
                    done = 1'b1;
                end
            end
            default: begin
                phase_q = RANGE_IDLE;
                if (req.start_req) begin
                    duty = ({16'd0, req.adc_sample} * {12'd0, pwm_period_q})
                           / {16'd0, SAMPLE_FULL};
                    pending_duty_q = duty[15:0];
                    alarm_q        = req.adc_sample > alarm_thr_q;
                    phase_q        = RANGE_TRIG_LOW;
                    phase_ticks_q  = '0;
                    pulse_ticks_q  = '0;
                end
            end
        endcase

        res.trigger_level = phase_q == RANGE_TRIG_HIGH;
        res.busy_res      = phase_q != RANGE_IDLE;
        res.done_res      = done;
        res.timed_out     = tmo_q;
        res.distance_cm   = distance_q;
        res.motor_duty    = applied_duty_q;
        res.motor_forward = fwd_q;
        res.alarm_on      = alarm_q;
    endtask

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            pwm_period_q   = RST_PWM_PERIOD;
            alarm_thr_q    = RST_ALARM_THRESHOLD;
            stop_dist_q    = RST_STOP_DISTANCE;
            rise_tmo_q     = RST_RISE_TIMEOUT;
            high_tmo_q     = RST_HIGH_TIMEOUT;
            scale_q        = RST_DISTANCE_SCALE;
            phase_q        = RANGE_IDLE;
            phase_ticks_q  = '0;
            pulse_ticks_q  = '0;
            pending_duty_q = '0;
            applied_duty_q = '0;
            distance_q     = '0;
            fwd_q          = 1'b0;
            alarm_q        = 1'b0;
            tmo_q          = 1'b0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PWM_PERIOD:      pwm_period_q = i_cfg_wdata[15:0];
                    CFG_ALARM_THRESHOLD: alarm_thr_q  = i_cfg_wdata[11:0];
                    CFG_STOP_DISTANCE:   stop_dist_q  = i_cfg_wdata[15:0];
                    CFG_RISE_TIMEOUT:    rise_tmo_q   = i_cfg_wdata[19:0];
                    CFG_HIGH_TIMEOUT:    high_tmo_q   = i_cfg_wdata[19:0];
                    CFG_DISTANCE_SCALE:  scale_q      = i_cfg_wdata[13:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                step_ranging(i_in_data, want);
                due_results.push_back(want);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (due_results.size() == 0) begin
                    report_mismatch("result without request", 1, 0);
                end else begin
                    want = due_results.pop_front();
                    if (got.trigger_level !== want.trigger_level)
                        report_mismatch("trigger_level", got.trigger_level, want.trigger_level);
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", got.busy_res, want.busy_res);
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", got.done_res, want.done_res);
                    if (got.timed_out !== want.timed_out)
                        report_mismatch("timed_out", got.timed_out, want.timed_out);
                    if (got.distance_cm !== want.distance_cm)
                        report_mismatch("distance_cm", got.distance_cm, want.distance_cm);
                    if (got.motor_duty !== want.motor_duty)
                        report_mismatch("motor_duty", got.motor_duty, want.motor_duty);
                    if (got.motor_forward !== want.motor_forward)
                        report_mismatch("motor_forward", got.motor_forward, want.motor_forward);
                    if (got.alarm_on !== want.alarm_on)
                        report_mismatch("alarm_on", got.alarm_on, want.alarm_on);
                end
                result_cnt++;
            end
        end
        o_pending    <= due_results.size();
        o_fail_count <= fail_cnt;
    end

endmodule

@@ tb/ultrasonic_range_obstacle_stop_tb.sv @@
// Testbench top for the ultrasonic range obstacle stop block: drives tick requests
// shaped as trigger, echo wait and echo pulse sequences across register settings.
// Depends on urs_pkg, the block itself and urs_range_checker.
module ultrasonic_range_obstacle_stop_tb;
    import urs_pkg::*;

    localparam int RUN_LIMIT = 2_000_000;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      cfg_we    = 1'b0;
    t_cfg_idx  cfg_idx   = CFG_PWM_PERIOD;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;
    int        fail_count;
    int        pending;

    logic      calm       = 1'b0;
    int        stall_left = 0;
    int        cycle_cnt  = 0;
    int        sent_items = 0;
    int        rise_lim   = 300000;
    int        high_lim   = 300000;

    ultrasonic_range_obstacle_stop i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    urs_range_checker u_range_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("ultrasonic_range_obstacle_stop_tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // Result side back-pressure: mostly short stalls, now and then a long one.
    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!calm && r < 20) begin
            out_ready  <= 1'b0;
            stall_left <= (r < 16) ? $urandom_range(0, 2) : $urandom_range(8, 30);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [11:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 12'h000;
        if (r == 1)
            return 12'hFFF;
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic send_item(input logic start, input logic [11:0] sample, input logic echo);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            if (in_valid)
                in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{start_req: start, adc_sample: sample, echo_level: echo};
        do @(posedge clk); while (!in_ready);
        sent_items++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    // One measurement: start request, trigger ticks with echo noise, echo wait,
    // echo pulse and the falling tick that closes it.
    task automatic run_measure(input logic [11:0] sample, input int rise_wait,
                               input int pulse, input bit noisy);
        send_item(1'b1, sample, 1'($urandom_range(0, 1)));
        for (int i = 0; i < TRIG_LOW_TICKS + TRIG_HIGH_TICKS - 1; i++)
            send_item(noisy && (i == 0 || $urandom_range(0, 9) == 0), pick_sample(),
                      1'($urandom_range(0, 1)));
        for (int i = 0; i < rise_wait; i++)
            send_item(noisy && $urandom_range(0, 19) == 0, pick_sample(), 1'b0);
        for (int i = 0; i < pulse; i++)
            send_item(noisy && $urandom_range(0, 19) == 0, pick_sample(), 1'b1);
        send_item(1'b0, pick_sample(), 1'b0);
    endtask

    task automatic measure_random();
        int rise_wait;
        int pulse;
        if (rise_lim <= 200 && $urandom_range(0, 99) < 15)
            rise_wait = rise_lim + $urandom_range(0, 3);
        else
            rise_wait = $urandom_range(0, (rise_lim <= 20) ? rise_lim - 1 : 20);
        if (high_lim <= 200 && $urandom_range(0, 99) < 15)
            pulse = high_lim + $urandom_range(0, 3);
        else
            pulse = $urandom_range(1, (high_lim <= 60) ? high_lim : 60);
        run_measure(pick_sample(), rise_wait, pulse, $urandom_range(0, 3) == 0);
    endtask

    // Walk the block back to idle from any phase, then let every result come out.
    task automatic settle_block();
        for (int i = 0; i < TRIG_LOW_TICKS + TRIG_HIGH_TICKS; i++)
            send_item(1'b0, pick_sample(), 1'b0);
        send_item(1'b0, pick_sample(), 1'b1);
        send_item(1'b0, pick_sample(), 1'b0);
        drain_results();
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [15:0] period, input logic [11:0] thr,
                                  input logic [15:0] stop, input logic [19:0] rise,
                                  input logic [19:0] high, input logic [13:0] scale);
        settle_block();
        put_reg(CFG_PWM_PERIOD, {4'd0, period});
        put_reg(CFG_ALARM_THRESHOLD, {8'd0, thr});
        put_reg(CFG_STOP_DISTANCE, {4'd0, stop});
        put_reg(CFG_RISE_TIMEOUT, rise);
        put_reg(CFG_HIGH_TIMEOUT, high);
        put_reg(CFG_DISTANCE_SCALE, {6'd0, scale});
        cfg_we   <= 1'b0;
        rise_lim = (rise == '0) ? 1 : int'(rise);
        high_lim = (high == '0) ? 1 : int'(high);
    endtask

    task automatic random_phase(input int quota);
        int first;
        int r;
        first = sent_items;
        while (sent_items - first < quota) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                measure_random();
            end else if (r < 92) begin
                repeat ($urandom_range(1, 8))
                    send_item($urandom_range(0, 9) < 3, pick_sample(),
                              1'($urandom_range(0, 1)));
            end else if (r < 96) begin
                drain_results();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_item(1'b0, pick_sample(), 1'b0);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-scale sample raising the alarm with a start request
        // while busy, then a zero sample; both measure a one-tick pulse.
        run_measure(12'hFFF, 0, 1, 1'b1);
        run_measure(12'h000, 0, 1, 1'b0);

        // Zero period and zero timeouts, which act like one.
        apply_settings(16'd0, 12'd0, 16'd0, 20'd0, 20'd0, 14'd10000);
        random_phase(170);
        apply_settings(16'd1, 12'd4095, 16'hFFFF, 20'd1, 20'd1, 14'd0);
        random_phase(170);
        calm <= 1'b1;
        apply_settings(16'hFFFF, 12'd2047, 16'd0, 20'd25, 20'd40, 14'h3FFF);
        random_phase(170);

        // Oversized scale with a long pulse drives the distance into saturation.
        apply_settings(16'hFFFF, 12'd100, 16'd5, 20'hFFFFF, 20'hFFFFF, 14'h3FFF);
        run_measure(12'hFFF, 2, 40010, 1'b0);
        calm <= 1'b0;
        random_phase(120);

        repeat (5) begin
            apply_settings(16'($urandom_range(0, 65535)), 12'($urandom_range(0, 4095)),
                           16'($urandom_range(0, 120)), 20'($urandom_range(1, 60)),
                           20'($urandom_range(1, 80)), 14'($urandom_range(0, 16383)));
            random_phase(160);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ultrasonic_range_obstacle_stop_tb OK");
        else
            $display("ultrasonic_range_obstacle_stop_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
src/urs_pkg.sv
src/urs_duty_div.sv
src/ultrasonic_range_obstacle_stop.sv
src/urs_checker.sv
tb/urs_range_checker.sv
tb/ultrasonic_range_obstacle_stop_tb.sv
